@@ sv/spectral_peak_pitch_shifter_defines.svh @@
// ----------------------------------------------------------------------------
// spectral_peak_pitch_shifter_defines.svh
// Assertion macros shared by the pitch shifter RTL.
// ----------------------------------------------------------------------------
`ifndef SPECTRAL_PEAK_PITCH_SHIFTER_DEFINES_SVH
`define SPECTRAL_PEAK_PITCH_SHIFTER_DEFINES_SVH

// Check a consequence in the same cycle as its antecedent.
`define SPP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its antecedent.
`define SPP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/spp_pkg.sv @@
// ----------------------------------------------------------------------------
// spp_pkg
// Types, codes and constants of the spectral peak pitch shifter.
// ----------------------------------------------------------------------------
`default_nettype none

package spp_pkg;

  localparam int MAG_W   = 24;
  localparam int OMAG_W  = 28;
  localparam int PH_W    = 16;
  localparam int IDX_W   = 10;
  localparam int CFG_W   = 24;
  localparam int RATIO_W = 16;
  localparam int FRAC_W  = 12;

  localparam logic [OMAG_W-1:0]  MAG_MAX   = {OMAG_W{1'b1}};
  localparam logic [RATIO_W-1:0] RATIO_RST = 16'd4096;
  localparam logic [15:0]        NWIN_RST  = 16'd1;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef logic [MAG_W-1:0]         mag_t;
  typedef logic [OMAG_W-1:0]        omag_t;
  typedef logic signed [PH_W-1:0]   phase_t;

  typedef enum logic [1:0] {
    REG_PITCH_RATIO,
    REG_PHASE_STEP,
    REG_NOISE_THR,
    REG_NUM_WINDOWS
  } spp_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PH_RD,
    S_PH_MUL,
    S_PH_ADV,
    S_PH_WR,
    S_DET,
    S_PK_START,
    S_PK_FIRST,
    S_PK_LOAD,
    S_PK_SHIFT,
    S_ACC_CHK,
    S_ACC_LO,
    S_ACC_HI,
    S_ACC_UPD,
    S_FINISH
  } spp_state_t;

endpackage

`default_nettype wire

@@ sv/spp_in_if.sv @@
// ----------------------------------------------------------------------------
// spp_in_if
// Input word channel: command plus bin magnitude and phase.
// ----------------------------------------------------------------------------
`default_nettype none

interface spp_in_if;
  import spp_pkg::*;

  logic   valid;
  logic   ready;
  logic   cmd;
  mag_t   magnitude;
  phase_t phase;

  modport source (output valid, cmd, magnitude, phase, input ready);
  modport sink   (input valid, cmd, magnitude, phase, output ready);
endinterface

`default_nettype wire

@@ sv/spp_out_if.sv @@
// ----------------------------------------------------------------------------
// spp_out_if
// Result word channel: one rebuilt bin per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface spp_out_if;
  import spp_pkg::*;

  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] bin_index;
  omag_t            out_magnitude;
  phase_t           out_phase;
  logic             last;

  modport source (output valid, bin_index, out_magnitude, out_phase, last, input ready);
  modport sink   (input valid, bin_index, out_magnitude, out_phase, last, output ready);
endinterface

`default_nettype wire

@@ sv/spp_ram.sv @@
// ----------------------------------------------------------------------------
// spp_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module spp_ram #(
  parameter int W = 16,
  parameter int D = 16,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem_r [D];
  logic [W-1:0] rdata_r;

  // write, then registered read that holds when idle
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ sv/spectral_peak_pitch_shifter.sv @@
// ----------------------------------------------------------------------------
// spectral_peak_pitch_shifter
// Peak-based spectral pitch shift of one frame of BINS magnitude/phase bins.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  in_bus    in   valid/ready    cmd, magnitude, phase
//  out_bus   out  valid/ready    bin_index, out_magnitude, out_phase, last
//  cfg_*     in   cfg_we         cfg_index, cfg_wdata
//
//  Loads and reads take one word per cycle; a read result leaves through the
//  RAM read registers and then the output register.
//  The last load starts a rebuild during which in_bus.ready is low: a phase
//  pass over the lower half that also clears the results, a peak search, and
//  per peak region an accumulation over its bins that land in range.
//  The rebuild is paced by the single read port of the magnitude and result RAMs.
//  Reset is synchronous; previous phases read as zero until first rebuild and after the window count wraps.
//  out_bus stalls hold the output register; reads then pause. BINS is even.
// ----------------------------------------------------------------------------
`default_nettype none

module spectral_peak_pitch_shifter #(
  parameter int BINS = 1024
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  spp_pkg::spp_reg_t         cfg_index,
  input  logic [spp_pkg::CFG_W-1:0] cfg_wdata,
  spp_in_if.sink                    in_bus,
  spp_out_if.source                 out_bus
);
  import spp_pkg::*;

  `include "spectral_peak_pitch_shifter_defines.svh"

  localparam int HALF = BINS / 2;
  localparam int IW   = $clog2(BINS);
  localparam int HW   = $clog2(HALF);
  localparam int PW   = RATIO_W + HW;
  localparam int SW   = HW + 6;

  localparam logic [IW-1:0] LAST_BIN = IW'(BINS - 1);
  localparam logic [HW:0]   HALF_X   = (HW+1)'(HALF);
  localparam logic [HW:0]   ZLO_X    = (HW+1)'(2);
  localparam logic [HW:0]   ZHI_X    = (HW+1)'(HALF - 3);

  // shift of a bin: floor(ratio*bin/4096) - bin
  function automatic logic signed [SW-1:0] shift_of(input logic [PW-1:0] prod,
                                                    input logic [HW-1:0] bin);
    logic [PW-FRAC_W-1:0] moved;
    moved = prod[PW-1:FRAC_W];
    return $signed({2'b00, moved}) - $signed({{(SW-HW){1'b0}}, bin});
  endfunction

  function automatic omag_t sat_add(input omag_t a, input mag_t b);
    logic [OMAG_W:0] sum;
    sum = {1'b0, a} + (OMAG_W+1)'(b);
    return (sum > (OMAG_W+1)'(MAG_MAX)) ? MAG_MAX : sum[OMAG_W-1:0];
  endfunction

  // ---------------- registers ----------------
  spp_state_t        state_r, state_nxt;
  logic [15:0]       ratio_r, step_r, nwin_r, wcnt_r, wcnt_nxt;
  mag_t              thr_r;
  logic [IW-1:0]     lp_r, lp_nxt, rp_r, rp_nxt;
  logic              frame_rdy_r, frame_rdy_nxt;
  logic              load_bank_r, load_bank_nxt, prev_zero_r, prev_zero_nxt;
  logic [HW-1:0]     i_r, i_nxt;
  logic [HW:0]       di_r, di_nxt;
  logic              dv_r, dv_nxt;
  logic [HW-1:0]     dn_r, dn_nxt;
  logic [HW-1:0]     pk_cnt_r, pk_cnt_nxt, k_r, k_nxt;
  logic [HW:0]       j_r, j_nxt, start_r, start_nxt;
  logic              p1_r, p1_nxt, out_valid_r, out_valid_nxt;

  logic [PW-1:0]     prod_r, prod_nxt;
  logic signed [SW-1:0] s_r, s_nxt;
  logic [15:0]       adv_r, adv_nxt;
  mag_t              win_r [4], win_nxt [4];
  logic [HW-1:0]     p_r, p_nxt, pn_r, pn_nxt, dst_r, dst_nxt;
  logic [HW:0]       end_r, end_nxt;
  mag_t              m_lo_r, m_lo_nxt, m_hi_r, m_hi_nxt;
  logic [IW-1:0]     p1_idx_r;
  logic              p1_up_r;
  logic [IDX_W-1:0]  out_idx_r;
  omag_t             out_mag_r;
  logic [PH_W-1:0]   out_ph_r;
  logic              out_last_r;

  // ---------------- memory ports ----------------
  logic              mag_we, mag_re;
  logic [IW-1:0]     mag_raddr;
  mag_t              mag_rdata;
  logic              ph_we, ph_re;
  logic [IW-1:0]     ph_waddr, ph_raddr;
  logic [PH_W-1:0]   ph_rdata;
  logic              rph_we, rph_re;
  logic [HW-1:0]     rlo_raddr, rhi_raddr;
  logic [PH_W-1:0]   rlo_rdata, rhi_rdata, rlo_wdata;
  logic              res_we, res_re;
  logic [IW-1:0]     res_waddr, res_raddr;
  omag_t             res_wdata, res_rdata;
  logic              pk_we, pk_re;
  logic [HW-1:0]     pk_waddr, pk_raddr, pk_wdata;
  logic [HW-1:0]     pk_rdata;

  logic              in_rdy, p1_adv, load_acc, read_acc, has_next, peak_hit;
  logic [15:0]       adv_mul, wcnt_inc;
  logic signed [SW-1:0] dst_s;
  mag_t              z3, z4;

  spp_ram #(.W(MAG_W),  .D(BINS))   u_mag (.clk, .we(mag_we), .waddr(lp_r),
    .wdata(in_bus.magnitude), .re(mag_re), .raddr(mag_raddr), .rdata(mag_rdata));
  spp_ram #(.W(PH_W),   .D(2*HALF)) u_ph  (.clk, .we(ph_we), .waddr(ph_waddr),
    .wdata(in_bus.phase), .re(ph_re), .raddr(ph_raddr), .rdata(ph_rdata));
  spp_ram #(.W(PH_W),   .D(HALF))   u_rlo (.clk, .we(rph_we), .waddr(i_r),
    .wdata(rlo_wdata), .re(rph_re), .raddr(rlo_raddr), .rdata(rlo_rdata));
  spp_ram #(.W(PH_W),   .D(HALF))   u_rhi (.clk, .we(rph_we), .waddr(i_r),
    .wdata(adv_r), .re(rph_re), .raddr(rhi_raddr), .rdata(rhi_rdata));
  spp_ram #(.W(OMAG_W), .D(BINS))   u_res (.clk, .we(res_we), .waddr(res_waddr),
    .wdata(res_wdata), .re(res_re), .raddr(res_raddr), .rdata(res_rdata));
  spp_ram #(.W(HW),     .D(HALF))   u_pk  (.clk, .we(pk_we), .waddr(pk_waddr),
    .wdata(pk_wdata), .re(pk_re), .raddr(pk_raddr), .rdata(pk_rdata));

  // ---------------- handshake ----------------
  assign p1_adv   = !out_valid_r || out_bus.ready;
  assign in_rdy   = (state_r == S_IDLE) && (!p1_r || p1_adv);
  assign load_acc = in_bus.valid && in_rdy && (in_bus.cmd == CMD_LOAD) && !frame_rdy_r;
  assign read_acc = in_bus.valid && in_rdy && (in_bus.cmd == CMD_READ) && frame_rdy_r;

  assign in_bus.ready          = in_rdy;
  assign out_bus.valid         = out_valid_r;
  assign out_bus.bin_index     = out_idx_r;
  assign out_bus.out_magnitude = out_mag_r;
  assign out_bus.out_phase     = out_ph_r;
  assign out_bus.last          = out_last_r;

  // ---------------- shared helpers ----------------
  assign adv_mul   = 16'(s_r) * step_r;
  assign rlo_wdata = (prev_zero_r ? '0 : ph_rdata) + adv_r;
  assign has_next  = ({1'b0, k_r} + (HW+1)'(1)) < {1'b0, pk_cnt_r};
  assign dst_s     = $signed({{(SW-HW-1){1'b0}}, j_r}) + s_r;
  assign wcnt_inc  = wcnt_r + 16'd1;

  // neighbors already passed are zeroed when below threshold
  assign z3 = (dn_r >= HW'(5) && win_r[2] < thr_r) ? '0 : win_r[2];
  assign z4 = (dn_r >= HW'(6) && win_r[3] < thr_r) ? '0 : win_r[3];
  assign peak_hit = (win_r[1] >= thr_r) && (win_r[1] > z4) && (win_r[1] > z3) &&
                    (win_r[1] > win_r[0]) && (win_r[1] > mag_rdata);

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt     = state_r;
    wcnt_nxt      = wcnt_r;
    lp_nxt        = lp_r;
    rp_nxt        = rp_r;
    frame_rdy_nxt = frame_rdy_r;
    load_bank_nxt = load_bank_r;
    prev_zero_nxt = prev_zero_r;
    i_nxt         = i_r;
    di_nxt        = di_r;
    dv_nxt        = 1'b0;
    dn_nxt        = dn_r;
    pk_cnt_nxt    = pk_cnt_r;
    k_nxt         = k_r;
    j_nxt         = j_r;
    start_nxt     = start_r;
    prod_nxt      = prod_r;
    s_nxt         = s_r;
    adv_nxt       = adv_r;
    win_nxt       = win_r;
    p_nxt         = p_r;
    pn_nxt        = pn_r;
    end_nxt       = end_r;
    dst_nxt       = dst_r;
    m_lo_nxt      = m_lo_r;
    m_hi_nxt      = m_hi_r;

    mag_we    = 1'b0;
    mag_re    = 1'b0;
    mag_raddr = '0;
    ph_we     = 1'b0;
    ph_waddr  = load_bank_r ? IW'(HALF) + lp_r : lp_r;
    ph_re     = 1'b0;
    ph_raddr  = load_bank_r ? IW'(i_r) : IW'(HALF) + IW'(i_r);
    rph_we    = 1'b0;
    rph_re    = 1'b0;
    rlo_raddr = rp_r[HW-1:0];
    rhi_raddr = HW'(LAST_BIN - rp_r);
    res_we    = 1'b0;
    res_waddr = IW'(i_r);
    res_wdata = '0;
    res_re    = 1'b0;
    res_raddr = rp_r;
    pk_we     = 1'b0;
    pk_waddr  = pk_cnt_r;
    pk_wdata  = dn_r - HW'(2);
    pk_re     = 1'b0;
    pk_raddr  = '0;

    unique case (state_r)
      S_IDLE: begin
        // store a loaded word; the last one starts the rebuild
        if (load_acc) begin
          mag_we = 1'b1;
          ph_we  = (lp_r < IW'(HALF));
          if (lp_r == LAST_BIN) begin
            lp_nxt     = '0;
            i_nxt      = '0;
            pk_cnt_nxt = '0;
            state_nxt  = S_PH_RD;
          end else begin
            lp_nxt = lp_r + IW'(1);
          end
        end
        // issue reads for one output word
        if (read_acc) begin
          res_re = 1'b1;
          rph_re = 1'b1;
          if (rp_r == LAST_BIN) begin
            rp_nxt        = '0;
            frame_rdy_nxt = 1'b0;
          end else begin
            rp_nxt = rp_r + IW'(1);
          end
        end
      end
      S_PH_RD: begin
        ph_re    = 1'b1;
        res_we   = 1'b1;
        prod_nxt = PW'(ratio_r) * PW'(i_r);
        state_nxt = S_PH_MUL;
      end
      S_PH_MUL: begin
        s_nxt     = shift_of(prod_r, i_r);
        res_we    = 1'b1;
        res_waddr = LAST_BIN - IW'(i_r);
        state_nxt = S_PH_ADV;
      end
      S_PH_ADV: begin
        adv_nxt   = adv_mul;
        state_nxt = S_PH_WR;
      end
      S_PH_WR: begin
        rph_we = 1'b1;
        if (i_r == HW'(HALF - 1)) begin
          load_bank_nxt = !load_bank_r;
          prev_zero_nxt = 1'b0;
          di_nxt        = '0;
          state_nxt     = S_DET;
        end else begin
          i_nxt     = i_r + HW'(1);
          state_nxt = S_PH_RD;
        end
      end
      S_DET: begin
        // stream the lower half through a five-bin window
        if (di_r < HALF_X) begin
          mag_re    = 1'b1;
          mag_raddr = IW'(di_r);
          di_nxt    = di_r + (HW+1)'(1);
          dv_nxt    = 1'b1;
          dn_nxt    = di_r[HW-1:0];
        end
        if (dv_r) begin
          win_nxt[0] = mag_rdata;
          win_nxt[1] = win_r[0];
          win_nxt[2] = win_r[1];
          win_nxt[3] = win_r[2];
          if (dn_r >= HW'(4) && peak_hit) begin
            pk_we      = 1'b1;
            pk_cnt_nxt = pk_cnt_r + HW'(1);
          end
          if (dn_r == HW'(HALF - 1)) begin
            state_nxt = S_PK_START;
          end
        end
      end
      S_PK_START: begin
        if (pk_cnt_r == '0) begin
          state_nxt = S_FINISH;
        end else begin
          pk_re     = 1'b1;
          k_nxt     = '0;
          start_nxt = '0;
          state_nxt = S_PK_FIRST;
        end
      end
      S_PK_FIRST: begin
        p_nxt     = pk_rdata;
        state_nxt = S_PK_LOAD;
      end
      S_PK_LOAD: begin
        prod_nxt = PW'(ratio_r) * PW'(p_r);
        pk_re    = has_next;
        pk_raddr = k_r + HW'(1);
        state_nxt = S_PK_SHIFT;
      end
      S_PK_SHIFT: begin
        s_nxt   = shift_of(prod_r, p_r);
        pn_nxt  = pk_rdata;
        end_nxt = has_next ? (({1'b0, p_r} + {1'b0, pk_rdata}) >> 1) : HALF_X;
        j_nxt   = start_r;
        state_nxt = S_ACC_CHK;
      end
      S_ACC_CHK: begin
        if (j_r >= end_r) begin
          if (has_next) begin
            start_nxt = end_r;
            p_nxt     = pn_r;
            k_nxt     = k_r + HW'(1);
            state_nxt = S_PK_LOAD;
          end else begin
            state_nxt = S_FINISH;
          end
        end else if (!dst_s[SW-1] && dst_s < SW'(HALF)) begin
          dst_nxt   = dst_s[HW-1:0];
          mag_re    = 1'b1;
          mag_raddr = IW'(j_r);
          state_nxt = S_ACC_LO;
        end else begin
          j_nxt = j_r + (HW+1)'(1);
        end
      end
      S_ACC_LO: begin
        m_lo_nxt  = (j_r >= ZLO_X && j_r <= ZHI_X && mag_rdata < thr_r) ? '0 : mag_rdata;
        mag_re    = 1'b1;
        mag_raddr = LAST_BIN - IW'(j_r);
        res_re    = 1'b1;
        res_raddr = IW'(dst_r);
        state_nxt = S_ACC_HI;
      end
      S_ACC_HI: begin
        m_hi_nxt  = mag_rdata;
        res_we    = 1'b1;
        res_waddr = IW'(dst_r);
        res_wdata = sat_add(res_rdata, m_lo_r);
        res_re    = 1'b1;
        res_raddr = LAST_BIN - IW'(dst_r);
        state_nxt = S_ACC_UPD;
      end
      S_ACC_UPD: begin
        res_we    = 1'b1;
        res_waddr = LAST_BIN - IW'(dst_r);
        res_wdata = sat_add(res_rdata, m_hi_r);
        j_nxt     = j_r + (HW+1)'(1);
        state_nxt = S_ACC_CHK;
      end
      S_FINISH: begin
        // count frames; drop previous phases when the window count wraps
        if (wcnt_inc >= nwin_r) begin
          wcnt_nxt      = '0;
          prev_zero_nxt = 1'b1;
        end else begin
          wcnt_nxt = wcnt_inc;
        end
        frame_rdy_nxt = 1'b1;
        rp_nxt        = '0;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // advance the read pipeline into the output register
  always_comb begin
    p1_nxt        = read_acc ? 1'b1 : (p1_adv ? 1'b0 : p1_r);
    out_valid_nxt = (p1_r && p1_adv) ? 1'b1 : (out_bus.ready ? 1'b0 : out_valid_r);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ratio_r     <= RATIO_RST;
      step_r      <= '0;
      thr_r       <= '0;
      nwin_r      <= NWIN_RST;
      wcnt_r      <= '0;
      lp_r        <= '0;
      rp_r        <= '0;
      frame_rdy_r <= 1'b0;
      load_bank_r <= 1'b0;
      prev_zero_r <= 1'b1;
      i_r         <= '0;
      di_r        <= '0;
      dv_r        <= 1'b0;
      dn_r        <= '0;
      pk_cnt_r    <= '0;
      k_r         <= '0;
      j_r         <= '0;
      start_r     <= '0;
      p1_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wcnt_r      <= wcnt_nxt;
      lp_r        <= lp_nxt;
      rp_r        <= rp_nxt;
      frame_rdy_r <= frame_rdy_nxt;
      load_bank_r <= load_bank_nxt;
      prev_zero_r <= prev_zero_nxt;
      i_r         <= i_nxt;
      di_r        <= di_nxt;
      dv_r        <= dv_nxt;
      dn_r        <= dn_nxt;
      pk_cnt_r    <= pk_cnt_nxt;
      k_r         <= k_nxt;
      j_r         <= j_nxt;
      start_r     <= start_nxt;
      p1_r        <= p1_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_PITCH_RATIO: ratio_r <= cfg_wdata[15:0];
          REG_PHASE_STEP:  step_r  <= cfg_wdata[15:0];
          REG_NOISE_THR:   thr_r   <= cfg_wdata[MAG_W-1:0];
          REG_NUM_WINDOWS: nwin_r  <= cfg_wdata[15:0];
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    s_r    <= s_nxt;
    adv_r  <= adv_nxt;
    win_r  <= win_nxt;
    p_r    <= p_nxt;
    pn_r   <= pn_nxt;
    end_r  <= end_nxt;
    dst_r  <= dst_nxt;
    m_lo_r <= m_lo_nxt;
    m_hi_r <= m_hi_nxt;
    if (read_acc) begin
      p1_idx_r <= rp_r;
      p1_up_r  <= (rp_r >= IW'(HALF));
    end
    if (p1_r && p1_adv) begin
      out_idx_r  <= IDX_W'(p1_idx_r);
      out_mag_r  <= res_rdata;
      out_ph_r   <= p1_up_r ? rhi_rdata : rlo_rdata;
      out_last_r <= (p1_idx_r == LAST_BIN);
    end
  end

  // ---------------- assertions ----------------
  `SPP_ASSERT_NOW(a_no_read_in_rebuild, state_r != S_IDLE, !p1_r,
    "read in flight during rebuild")
  `SPP_ASSERT_NEXT(a_last_load_rebuilds, load_acc && lp_r == LAST_BIN, state_r == S_PH_RD,
    "last load did not start the rebuild")
  `SPP_ASSERT_NOW(a_result_write_rebuild, res_we, state_r != S_IDLE,
    "result RAM written outside the rebuild")
  `SPP_ASSERT_NOW(a_peak_in_range, pk_we, pk_cnt_r < HW'(HALF - 4),
    "peak list overflow")

endmodule

`default_nettype wire
